### hdl/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared codes, state type and controller/datapath signal groups for the
// bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

	localparam int ACTION_W = 2;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the incoming item
		logic exec;     // evaluate the item and record its status
		logic apply;    // the operation is legal: move pointers, touch memory
		logic respond;  // present the result for one cycle
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_push;
		logic full;
		logic empty;
	} flags_t;

endpackage

### hdl/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries.
// Each item goes through accept, execute (with one memory port access) and respond;
// busy stays high from accept through respond, so a new item is taken only once the
// previous one is through.
// Reset clears head, tail and count at once; storage is not cleared.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic        [bdeq_pkg::ACTION_W-1:0]  action,
	input  logic signed [bdeq_pkg::WORD_W-1:0]    value,
	output logic                                  done,
	output logic signed [bdeq_pkg::WORD_W-1:0]    popped_value,
	output logic        [bdeq_pkg::STATUS_W-1:0]  status,
	output logic        [bdeq_pkg::OCC_W-1:0]     occupancy
);
	import bdeq_pkg::*;

	cmd_t   cmd;
	flags_t flags;

	// Controller: walks each item through accept, execute and respond,
	// and decides from the datapath flags whether the operation is legal.
	bdeq_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: hold the item, move the pointers, write or read one entry,
	// and keep the result registers stable through the respond cycle.
	bdeq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.flags        (flags),
		.action       (action),
		.value        (value),
		.popped_value (popped_value),
		.status       (status),
		.occupancy    (occupancy)
	);

	// Strobe the result in the respond cycle only.
	assign done = cmd.respond;

endmodule

### hdl/bdeq_controller.sv
// ----------------------------------------------------------------------------
// bdeq_controller
// Sequencer for one item: accept, execute, respond.
// ----------------------------------------------------------------------------
module bdeq_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bdeq_pkg::flags_t flags,
	output bdeq_pkg::cmd_t   cmd,
	output logic             busy
);
	import bdeq_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   legal;

	// A push needs a free slot, a pop needs an entry.
	assign legal = flags.is_push ? !flags.full : !flags.empty;

	always_comb begin
		cmd        = '0;
		busy       = 1'b1;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load   = 1'b1;
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec   = 1'b1;
				cmd.apply  = legal;
				state_next = S_RESP;
			end
			S_RESP: begin
				cmd.respond = 1'b1;
				state_next  = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

### hdl/bdeq_datapath.sv
// ----------------------------------------------------------------------------
// bdeq_datapath
// Ring storage, head/tail pointers, entry count and result registers.
// ----------------------------------------------------------------------------
module bdeq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bdeq_pkg::cmd_t                        cmd,
	output bdeq_pkg::flags_t                      flags,
	input  logic        [bdeq_pkg::ACTION_W-1:0]  action,
	input  logic signed [bdeq_pkg::WORD_W-1:0]    value,
	output logic signed [bdeq_pkg::WORD_W-1:0]    popped_value,
	output logic        [bdeq_pkg::STATUS_W-1:0]  status,
	output logic        [bdeq_pkg::OCC_W-1:0]     occupancy
);
	import bdeq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic        [ACTION_W-1:0] action_q;
	logic signed [WORD_W-1:0]   value_q;
	logic        [IW-1:0]       head_q;
	logic        [IW-1:0]       tail_q;
	logic        [CW-1:0]       count_q;
	logic signed [WORD_W-1:0]   mem [DEPTH];
	logic signed [WORD_W-1:0]   rd_data_q;
	logic        [STATUS_W-1:0] status_q;
	logic                       pop_ok_q;

	logic [IW-1:0] head_next;
	logic [IW-1:0] head_prev;
	logic [IW-1:0] tail_next;
	logic [IW-1:0] tail_prev;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic          is_push;

	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	assign is_push = (action_q == ACT_PUSH_BACK) || (action_q == ACT_PUSH_FRONT);
	assign wr_addr = (action_q == ACT_PUSH_BACK) ? tail_q : head_prev;
	assign rd_addr = (action_q == ACT_POP_FRONT) ? head_q : tail_prev;

	assign flags.is_push = is_push;
	assign flags.full    = (count_q == FULL_CNT);
	assign flags.empty   = (count_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			value_q  <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.apply) begin
			case (action_q)
				ACT_PUSH_BACK:  tail_q <= tail_next;
				ACT_PUSH_FRONT: head_q <= head_prev;
				ACT_POP_FRONT:  head_q <= head_next;
				default:        tail_q <= tail_prev;
			endcase
			count_q <= is_push ? count_q + 1'b1 : count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && is_push) begin
			mem[wr_addr] <= value_q;
		end
		if (cmd.apply && !is_push) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_OK;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			status_q <= cmd.apply ? ST_OK : (is_push ? ST_FULL : ST_EMPTY);
			pop_ok_q <= cmd.apply && !is_push;
		end
	end

	assign popped_value = pop_ok_q ? rd_data_q : '0;
	assign status       = status_q;
	assign occupancy    = OCC_W'(count_q);

endmodule

### hdl/bdeq_checker.sv
// ----------------------------------------------------------------------------
// bdeq_checker
// Port-level checks on the command handshake and result strobe.
// ----------------------------------------------------------------------------
module bdeq_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic                                  done,
	input logic signed [bdeq_pkg::WORD_W-1:0]    popped_value,
	input logic        [bdeq_pkg::STATUS_W-1:0]  status
);
	import bdeq_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepting an item");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result not strobed two cycles after accept");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (popped_value == '0))
		else $error("nonzero popped value on a failed item");

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (.*);
